// ===== hdl/cdtum_pkg.sv =====
package cdtum_pkg;

  localparam int unsigned MillisW = 42;
  localparam int unsigned DaysW   = 16;
  localparam int unsigned SodW    = 17;
  localparam int unsigned SecsW   = 32;

  localparam logic [MillisW-1:0] FallbackReset = 42'd1735689600000;

  localparam logic [13:0] YearMin = 14'd2020;
  localparam logic [13:0] YearMax = 14'd2100;
  localparam logic [6:0]  YearEnd = 7'd80;    // 2100 - 2020, a century year with no leap day

  localparam logic [DaysW-1:0] DaysTo2020  = 16'd18262;
  localparam logic [DaysW-1:0] DaysPerYear = 16'd365;
  localparam logic [SecsW-1:0] SecsPerDay  = 32'd86400;
  localparam logic [MillisW-1:0] MsPerSec  = 42'd1000;

  typedef struct packed {
    logic             rejected;
    logic [DaysW-1:0] days;
    logic [SodW-1:0]  sod;
  } cdtum_s1_t;

  // Days before the first of the month, month given as 1..12.
  function automatic logic [8:0] days_before_month(input logic [3:0] month);
    logic [8:0] d;
    case (month)
      4'd1:    d = 9'd0;
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

// ===== hdl/cdtum_front.sv =====
module cdtum_front import cdtum_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic       too_short_i,
  input  logic [13:0] year_i,
  input  logic [6:0] month_i,
  input  logic [6:0] day_i,
  input  logic [6:0] hour_i,
  input  logic [6:0] minute_i,
  input  logic [6:0] second_i,
  output logic       valid_o,
  output cdtum_s1_t  s1_o
);

  logic            valid_q;
  cdtum_s1_t       s1_d, s1_q;
  logic [6:0]      yo;
  logic [7:0]      leaps;
  logic            leap_now;
  logic [DaysW-1:0] days_in_year;

  always_comb begin
    s1_d.rejected = too_short_i
                  || !(year_i inside {[YearMin:YearMax]})
                  || !(month_i inside {[7'd1:7'd12]})
                  || !(day_i inside {[7'd1:7'd31]})
                  || (hour_i > 7'd23) || (minute_i > 7'd59) || (second_i > 7'd59);

    // Year offset from 2020; only meaningful when the year is in range
    yo       = 7'(year_i - YearMin);
    // Leap years in 2020..year-1: every fourth, 2100 never reached
    leaps    = ({1'b0, yo} + 8'd3) >> 2;
    leap_now = (yo[1:0] == 2'b00) && (yo != YearEnd);

    days_in_year = {7'd0, days_before_month(month_i[3:0])}
                 + {15'd0, (month_i > 7'd2) && leap_now}
                 + {9'd0, 7'(day_i - 7'd1)};

    s1_d.days = DaysTo2020
              + 16'(DaysPerYear * {9'd0, yo})
              + {8'd0, leaps}
              + days_in_year;

    s1_d.sod = 17'({10'd0, hour_i} * 17'd3600)
             + 17'({10'd0, minute_i} * 17'd60)
             + {10'd0, second_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q <= s1_d;
  end

  assign valid_o = valid_q;
  assign s1_o    = s1_q;

endmodule

// ===== hdl/calendar_datetime_to_unix_millis.sv =====
// Converts a split UTC date and time to Unix time in milliseconds.
//
// Input channel: drive the fields and pulse start_i; a transfer happens at
// every rising edge with start_i high and busy_o low. busy_o is always low,
// so one item may be taken in every cycle.
// Result channel: done_o is high for exactly one cycle with unix_millis_o
// and used_fallback_o; the receiver cannot stall it and must take it then.
// done_o rises once the item has passed the front register, the second-stage
// register and the output register; throughput is one item per cycle.
// Stage one checks ranges and counts days and second of day, stage two
// multiplies days by 86400, stage three scales by 1000 and picks the
// fallback for a rejected item.
// Rejected items (short string, field out of range, year not in 2020..2100)
// return the fallback register and raise used_fallback_o.
// Configuration: fallback_we_i writes fallback_wdata_i into the register;
// write only while no item is in flight.
// Reset empties the pipeline and loads the fallback with 2025-01-01 00:00:00.
module calendar_datetime_to_unix_millis import cdtum_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  logic              too_short_i,
  input  logic [13:0]       year_i,
  input  logic [6:0]        month_i,
  input  logic [6:0]        day_i,
  input  logic [6:0]        hour_i,
  input  logic [6:0]        minute_i,
  input  logic [6:0]        second_i,
  input  logic              fallback_we_i,
  input  logic [MillisW-1:0] fallback_wdata_i,
  output logic              done_o,
  output logic [MillisW-1:0] unix_millis_o,
  output logic              used_fallback_o
);

  logic              s1_valid;
  cdtum_s1_t         s1;
  logic              s2_valid_q;
  logic              s2_rej_q;
  logic [SecsW-1:0]  secs_d, secs_q;
  logic [MillisW-1:0] fallback_q;
  logic              done_q;
  logic              used_q;
  logic [MillisW-1:0] millis_d, millis_q;

  assign busy_o = 1'b0;

  cdtum_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .too_short_i (too_short_i),
    .year_i      (year_i),
    .month_i     (month_i),
    .day_i       (day_i),
    .hour_i      (hour_i),
    .minute_i    (minute_i),
    .second_i    (second_i),
    .valid_o     (s1_valid),
    .s1_o        (s1)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fallback_q <= FallbackReset;
    end else if (fallback_we_i) begin
      fallback_q <= fallback_wdata_i;
    end
  end

  // Seconds since the epoch fit in 32 bits for years up to 2100
  assign secs_d = 32'({16'd0, s1.days} * SecsPerDay) + {15'd0, s1.sod};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      s2_valid_q <= s1_valid;
      done_q     <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_rej_q <= s1.rejected;
    secs_q   <= secs_d;
  end

  always_comb begin
    if (s2_rej_q) begin
      millis_d = fallback_q;
    end else begin
      millis_d = 42'({10'd0, secs_q} * MsPerSec);
    end
  end

  always_ff @(posedge clk_i) begin
    used_q   <= s2_rej_q;
    millis_q <= millis_d;
  end

  assign done_o          = done_q;
  assign unix_millis_o   = millis_q;
  assign used_fallback_o = used_q;

  // A result strobe only ever follows an item held in the second stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(s2_valid_q))
    else $error("result strobe without an item in flight");

  // An accepted item in range never yields a time before 2020
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid && !s1.rejected) |-> (s1.days >= DaysTo2020))
    else $error("day count below 2020 for an accepted date");

  // A rejected item carries the fallback value unchanged
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && used_fallback_o && $stable(fallback_q)) |-> (unix_millis_o == fallback_q))
    else $error("rejected item did not return the fallback");

endmodule
